### hdl/timed_credit_history_table_top_assert.svh
// assertion macros for the timed credit history table checker
`ifndef TIMED_CREDIT_HISTORY_TABLE_TOP_ASSERT_SVH
`define TIMED_CREDIT_HISTORY_TABLE_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define TCHT_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("tcht checker: same-cycle property failed");

// next-cycle implication, masked during reset
`define TCHT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("tcht checker: next-cycle property failed");

// next-cycle implication, checked through reset as well
`define TCHT_ASSERT_RST(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("tcht checker: reset property failed");

`endif

### hdl/tcht_pkg.sv
// ----------------------------------------------------------------------------
// tcht_pkg
// shared types, codes and saturating helpers of the credit history table
// ----------------------------------------------------------------------------
package tcht_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam logic [7:0] BUFFER_SIZE_RST = 8'd4;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_RECV  = 2'd1;
  localparam logic [1:0] OP_PRUNE = 2'd2;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_BEFORE   = 2'd2;
  localparam logic [1:0] ERR_ORDER    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] item_time;
    logic [7:0]  item_length;
  } item_t;

  typedef struct packed {
    logic        granted;
    logic [63:0] start_time;
    logic [1:0]  error;
  } res_t;

  typedef struct packed {
    logic [63:0] etime;
    logic [7:0]  credits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [8:0] b);
    logic [9:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 10'd255) ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

endpackage

### hdl/tcht_ram.sv
// ----------------------------------------------------------------------------
// tcht_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/tcht_seq.sv
// ----------------------------------------------------------------------------
// tcht_seq
// sequencer that scans and rewrites the history table one entry at a time
// ----------------------------------------------------------------------------
module tcht_seq #(
  parameter int MAX_ENTRIES = tcht_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tcht_pkg::item_t                in_item,
  output logic                           res_valid,
  input  logic                           res_ready,
  output tcht_pkg::res_t                 res,
  output logic                           ram_we,
  output logic [$clog2(MAX_ENTRIES)-1:0] ram_waddr,
  output tcht_pkg::entry_t               ram_wdata,
  output logic [$clog2(MAX_ENTRIES)-1:0] ram_raddr,
  input  tcht_pkg::entry_t               ram_rdata
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(MAX_ENTRIES);
  localparam logic [CW-1:0] FULL_W  = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE_W   = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_EV, S_D_HRD, S_D_HEV, S_D_RD, S_D_EV,
    S_W_RD, S_W_EV, S_R_RD, S_R_EV, S_R_APP, S_FIN
  } state_t;

  state_t          state;
  logic            init_pending;
  logic [7:0]      buffer_size;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic [CW-1:0]   k;
  logic [CW-1:0]   p;
  logic [AW-1:0]   hslot;
  logic [63:0]     t_r;
  logic [7:0]      len;
  logic [63:0]     dtime;
  logic [7:0]      dn;
  logic [63:0]     tt;
  logic [63:0]     diff;
  logic [7:0]      c;
  logic [7:0]      hc;
  logic [7:0]      i;
  logic            merge;
  logic            granted;
  logic [63:0]     start;
  logic [1:0]      err;

  logic [CW-1:0]   slot_k;
  logic [AW:0]     slot_sum;
  logic [AW-1:0]   slot_addr;
  logic [63:0]     st_c;
  logic [64:0]     dt_sum;
  logic [63:0]     dt_c;
  logic [63:0]     diff_c;
  logic            i_eq;
  logic            i_gt;
  logic [7:0]      ahead;
  logic [64:0]     app_sum;
  logic [7:0]      app_cred;
  logic            do_app;
  logic            full;
  logic [7:0]      hc_inc;
  logic            last_i;
  logic            last_k;

  // circular slot address of the entry being visited
  always_comb begin
    slot_k    = (state == S_R_APP) ? count : k;
    slot_sum  = {1'b0, head} + {1'b0, slot_k[AW-1:0]};
    slot_addr = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : slot_sum[AW-1:0];
  end

  // datapath helpers
  always_comb begin
    st_c     = (ram_rdata.etime > t_r) ? ram_rdata.etime : t_r;
    dt_sum   = {1'b0, st_c} + {57'd0, len};
    dt_c     = dt_sum[64] ? {64{1'b1}} : dt_sum[63:0];
    diff_c   = ram_rdata.etime - t_r;
    i_eq     = ({56'd0, i} == diff);
    i_gt     = ({56'd0, i} > diff);
    ahead    = i - diff[7:0];
    app_sum  = merge ? ({1'b0, tt} + {57'd0, ahead}) : ({1'b0, t_r} + {57'd0, i});
    app_cred = merge ? tcht_pkg::sat_add(hc, {1'b0, ahead})
                     : tcht_pkg::sat_add(c, {1'b0, i} + 9'd1);
    do_app   = merge ? i_gt : 1'b1;
    full     = (count >= FULL_W);
    hc_inc   = tcht_pkg::sat_add(hc, {1'b0, i} + 9'd1);
    last_i   = (i == len - 8'd1);
    last_k   = (k == count - ONE_W);
  end

  // memory access of the current step
  always_comb begin
    ram_raddr = slot_addr;
    ram_we    = 1'b0;
    ram_waddr = slot_addr;
    ram_wdata = '0;
    if (init_pending || cfg_we) begin
      ram_we            = 1'b1;
      ram_waddr         = '0;
      ram_wdata.etime   = '0;
      ram_wdata.credits = cfg_we ? cfg_data : buffer_size;
    end else begin
      case (state)
        S_W_EV: begin
          ram_we            = 1'b1;
          ram_wdata.etime   = (k == p) ? dtime : ram_rdata.etime;
          ram_wdata.credits = tcht_pkg::sat_sub(ram_rdata.credits, dn);
        end
        S_R_EV: begin
          // merge that lands wholly on the single entry
          if (ram_rdata.etime >= t_r && count == ONE_W && diff_c >= {56'd0, len}) begin
            ram_we            = 1'b1;
            ram_wdata.etime   = ram_rdata.etime;
            ram_wdata.credits = tcht_pkg::sat_add(ram_rdata.credits, {1'b0, len});
          end
        end
        S_R_APP: begin
          if (merge && i_eq) begin
            ram_we            = 1'b1;
            ram_waddr         = head;
            ram_wdata.etime   = tt;
            ram_wdata.credits = hc_inc;
          end else if (do_app && !app_sum[64] && !full) begin
            ram_we            = 1'b1;
            ram_wdata.etime   = app_sum[63:0];
            ram_wdata.credits = app_cred;
          end
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE) && !init_pending;
  assign res_valid = (state == S_FIN);
  assign res       = '{granted: granted, start_time: start, error: err};

  // sequencer state and table registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      init_pending <= 1'b1;
      buffer_size  <= tcht_pkg::BUFFER_SIZE_RST;
      head         <= '0;
      count        <= ONE_W;
    end else begin
      init_pending <= 1'b0;
      if (cfg_we) begin
        buffer_size <= cfg_data;
        head        <= '0;
        count       <= ONE_W;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            t_r     <= in_item.item_time;
            len     <= in_item.item_length;
            start   <= in_item.item_time;
            granted <= 1'b0;
            err     <= tcht_pkg::ERR_OK;
            k       <= '0;
            case (in_item.operation)
              tcht_pkg::OP_ALLOC: state <= S_A_RD;
              tcht_pkg::OP_RECV: begin
                k     <= count - ONE_W;
                state <= S_R_RD;
              end
              tcht_pkg::OP_PRUNE: begin
                dtime <= in_item.item_time;
                dn    <= 8'd0;
                state <= S_D_HRD;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        // allocate: first entry with enough credits
        S_A_RD: state <= S_A_EV;
        S_A_EV: begin
          if (ram_rdata.credits >= len) begin
            start   <= st_c;
            granted <= 1'b1;
            dtime   <= dt_c;
            dn      <= len;
            k       <= '0;
            state   <= S_D_HRD;
          end else if (last_k) begin
            state <= S_FIN;
          end else begin
            k     <= k + ONE_W;
            state <= S_A_RD;
          end
        end
        // decrease: check head, then find the last entry not after dtime
        S_D_HRD: state <= S_D_HEV;
        S_D_HEV: begin
          if (ram_rdata.etime > dtime) begin
            err   <= tcht_pkg::ERR_BEFORE;
            state <= S_FIN;
          end else begin
            p <= '0;
            if (count == ONE_W) begin
              k     <= '0;
              state <= S_W_RD;
            end else begin
              k     <= ONE_W;
              state <= S_D_RD;
            end
          end
        end
        S_D_RD: state <= S_D_EV;
        S_D_EV: begin
          if (ram_rdata.etime > dtime) begin
            k     <= p;
            state <= S_W_RD;
          end else begin
            p <= k;
            if (last_k) begin
              state <= S_W_RD;
            end else begin
              k     <= k + ONE_W;
              state <= S_D_RD;
            end
          end
        end
        // rewrite pass from the new head to the tail
        S_W_RD: state <= S_W_EV;
        S_W_EV: begin
          if (k == p) begin
            hslot <= slot_addr;
          end
          if (last_k) begin
            head  <= (k == p) ? slot_addr : hslot;
            count <= count - p;
            state <= S_FIN;
          end else begin
            k     <= k + ONE_W;
            state <= S_W_RD;
          end
        end
        // receive: look at the tail entry
        S_R_RD: state <= S_R_EV;
        S_R_EV: begin
          tt <= ram_rdata.etime;
          c  <= ram_rdata.credits;
          hc <= ram_rdata.credits;
          i  <= 8'd0;
          if (ram_rdata.etime < t_r) begin
            merge <= 1'b0;
            state <= (len == 8'd0) ? S_FIN : S_R_APP;
          end else if (count != ONE_W) begin
            err   <= tcht_pkg::ERR_ORDER;
            state <= S_FIN;
          end else begin
            merge <= 1'b1;
            diff  <= diff_c;
            state <= (diff_c >= {56'd0, len}) ? S_FIN : S_R_APP;
          end
        end
        // one credit per cycle: append or merge
        S_R_APP: begin
          if (merge && i_eq) begin
            hc    <= hc_inc;
            i     <= i + 8'd1;
            state <= last_i ? S_FIN : S_R_APP;
          end else if (do_app) begin
            if (app_sum[64]) begin
              state <= S_FIN;
            end else if (full) begin
              err   <= tcht_pkg::ERR_FULL;
              state <= S_FIN;
            end else begin
              count <= count + ONE_W;
              i     <= i + 8'd1;
              state <= last_i ? S_FIN : S_R_APP;
            end
          end else begin
            i     <= i + 8'd1;
            state <= last_i ? S_FIN : S_R_APP;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/timed_credit_history_table_top.sv
// Timed credit history table. One operation per input transaction (allocate,
// receive, prune) and exactly one result transaction each. All work goes
// through one table memory with a registered read: allocate scans the
// entries up to and including the first fitting one, then runs the collapse
// search (the head and every entry up to the first one after the collapse
// time) and the rewrite pass from the new head to the tail; prune runs the
// last two parts only; receive looks at the tail entry and then handles the
// returned credits one at a time. Each transaction also passes through the
// accepting idle state and the result state; a result waiting in the output
// register holds the sequencer only while that register is still full.
// After reset the block writes the initial entry and then takes input; a
// buffer_size write re-initializes the table.
// ----------------------------------------------------------------------------
// timed_credit_history_table_top
// stream wrapper with output register around the table sequencer and memory
// ----------------------------------------------------------------------------
module timed_credit_history_table_top #(
  parameter int MAX_ENTRIES = tcht_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // item_time[63:0], item_length[71:64]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // granted[0], start_time[64:1], error[66:65], zero
);

  localparam int AW = $clog2(MAX_ENTRIES);

  tcht_pkg::item_t  item;
  tcht_pkg::res_t   res;
  logic             res_valid;
  logic             res_ready;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  tcht_pkg::entry_t ram_wdata;
  tcht_pkg::entry_t ram_rdata;
  logic [tcht_pkg::ENTRY_W-1:0] ram_rword;

  assign item = '{operation: s_tuser, item_time: s_tdata[63:0], item_length: s_tdata[71:64]};

  tcht_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcht_ram #(.WIDTH(tcht_pkg::ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rword)
  );

  assign ram_rdata = tcht_pkg::entry_t'(ram_rword);

  // output register, frees the sequencer while a result waits
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {5'd0, res.error, res.start_time, res.granted};
    end
  end

endmodule

### hdl/tcht_checker.sv
// ----------------------------------------------------------------------------
// tcht_checker
// port-level checks of the credit history table, bound to the top level
// ----------------------------------------------------------------------------
`include "timed_credit_history_table_top_assert.svh"

module tcht_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [7:0]  cfg_data,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [71:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // a stalled result stays offered
  `TCHT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // a granted allocation never reports a full table or a receive order error
  `TCHT_ASSERT_NOW(a_grant_err, clk, rst, m_tvalid && m_tdata[0],
    m_tdata[66:65] != tcht_pkg::ERR_FULL && m_tdata[66:65] != tcht_pkg::ERR_ORDER)

  // padding bits of the result stay zero
  `TCHT_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[71:67] == 5'd0)

  // no input and no result right after reset, while the table initializes
  `TCHT_ASSERT_RST(a_rst_quiet, clk, rst, !s_tready && !m_tvalid)

  // an accepted transaction is not followed by another accept in the next cycle
  `TCHT_ASSERT_NEXT(a_one_busy, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind timed_credit_history_table_top tcht_checker u_tcht_checker (.*);
